// File: rtl/core/rhpc_pkg.sv
// Shared types, constants and helper functions for the ROM header patcher.
// Used by the channel interfaces and the rom_header_patch_checksum top level.
package rhpc_pkg;

  localparam int unsigned ADDR_BITS_DEF = 23;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned HSUM_W        = 8;
  localparam int unsigned GSUM_W        = 16;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned TITLE_LEN     = 15;
  localparam int unsigned LOGO_LEN      = 48;

  // Header map.
  localparam int unsigned LOGO_START = 32'h104;
  localparam int unsigned TITLE_START = 32'h134;
  localparam int unsigned HDR_COLOR   = 32'h143;
  localparam int unsigned HDR_LIC_HI  = 32'h144;
  localparam int unsigned HDR_LIC_LO  = 32'h145;
  localparam int unsigned HDR_OLD_SGB = 32'h146;
  localparam int unsigned HDR_TYPE    = 32'h147;
  localparam int unsigned HDR_ROM     = 32'h148;
  localparam int unsigned HDR_RAM     = 32'h149;
  localparam int unsigned HDR_DEST    = 32'h14A;
  localparam int unsigned HDR_OLD_LIC = 32'h14B;
  localparam int unsigned HDR_VERSION = 32'h14C;
  localparam int unsigned HDR_SUM_AT  = 32'h14D;
  localparam int unsigned GSUM_AT     = 32'h14E;

  localparam logic [BYTE_W-1:0] COLOR_FLAG   = 8'h80;
  localparam logic [BYTE_W-1:0] DEST_BYTE    = 8'h01;
  localparam logic [BYTE_W-1:0] OLD_LIC_BYTE = 8'h33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TITLE_LOW  = 3'd0,
    CFG_TITLE_HIGH = 3'd1,
    CFG_COLOR_MODE = 3'd2,
    CFG_LICENSE    = 3'd3,
    CFG_CART_TYPE  = 3'd4,
    CFG_ROM_BANK   = 3'd5,
    CFG_RAM_SIZE   = 3'd6
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] LOGO_TABLE [LOGO_LEN] = '{
    8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0c, 8'h00, 8'h0d,
    8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
    8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99,
    8'hbb, 8'hbb, 8'h67, 8'h63, 8'h6e, 8'h0e, 8'hec, 8'hcc,
    8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e
  };

  // Uppercase ASCII hex digit of the low nibble.
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h37 + {4'h0, n};
  endfunction

  // Only a to z are changed; every other code passes as given.
  function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/rhpc_if.sv
// Valid/ready channel interfaces for the ROM header patcher.
// Depends on rhpc_pkg for the field widths.
interface rhpc_in_if import rhpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rom_byte;
  logic              final_byte;

  modport source (output valid, rom_byte, final_byte, input ready);
  modport sink   (input valid, rom_byte, final_byte, output ready);
endinterface

interface rhpc_out_if import rhpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_summary;
  logic [HSUM_W-1:0] header_checksum;
  logic [GSUM_W-1:0] global_checksum;
  logic              run_end;

  modport source (output valid, out_byte, is_summary, header_checksum, global_checksum,
                  run_end, input ready);
  modport sink   (input valid, out_byte, is_summary, header_checksum, global_checksum,
                  run_end, output ready);
endinterface

// File: rtl/core/rom_header_patch_checksum.sv
// ROM header patcher: streams image bytes, fills in the header and keeps checksums.
// Depends on rhpc_pkg and the channel interfaces in rhpc_if.sv.
//
//   Channel   Direction  Handshake      Carries
//   in_s      sink       valid/ready    rom_byte, final_byte
//   out_m     source     valid/ready    out_byte, is_summary, header_checksum,
//                                       global_checksum, run_end
//   cfg       input      cfg_we_i       cfg_idx_i, cfg_wdata_i (write only)
//
// Each byte is patched in the cycle it is accepted and appears on out_m in the next
// cycle, so one byte a cycle passes while the sink keeps ready high and no summary waits.
// A final byte is followed by a summary item; the input is held off from the cycle after
// the final byte is taken until the patched byte has left the output register.
// The ready path is combinational from out_m.ready: a stalled sink stalls the
// source in the same cycle, with nothing lost.
// Reset is asynchronous and active low; it clears the address, both sums, the
// output valid and every configuration register.

module rom_header_patch_checksum import rhpc_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rhpc_in_if.sink               in_s,
  rhpc_out_if.source            out_m
);

  localparam logic [ADDR_BITS-1:0] A_LOGO  = ADDR_BITS'(LOGO_START);
  localparam logic [ADDR_BITS-1:0] A_TITLE = ADDR_BITS'(TITLE_START);
  localparam logic [ADDR_BITS-1:0] A_TEND  = ADDR_BITS'(TITLE_START + TITLE_LEN);
  localparam logic [ADDR_BITS-1:0] A_VER   = ADDR_BITS'(HDR_VERSION);
  localparam logic [ADDR_BITS-1:0] A_GSUM0 = ADDR_BITS'(GSUM_AT);
  localparam logic [ADDR_BITS-1:0] A_GSUM1 = ADDR_BITS'(GSUM_AT + 1);

  // Configuration registers, kept across images.
  logic [63:0] title_low_q;
  logic [55:0] title_high_q;
  logic        color_mode_q;
  logic [7:0]  license_q;
  logic [7:0]  cart_type_q;
  logic [7:0]  rom_bank_q;
  logic [7:0]  ram_size_q;

  // Running state of the current image.
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [HSUM_W-1:0]    hsum_q, hsum_d;
  logic [GSUM_W-1:0]    gsum_q, gsum_d;

  // Output register and the summary that waits behind it.
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_summ_q;
  logic [HSUM_W-1:0] out_hck_q;
  logic [GSUM_W-1:0] out_gck_q;
  logic              out_end_q;
  logic              pend_q;
  logic [HSUM_W-1:0] pend_hck_q;
  logic [GSUM_W-1:0] pend_gck_q;

  logic              in_ready;
  logic              in_fire;
  logic              out_fire;
  logic [BYTE_W-1:0] patched;
  logic [119:0]      title_all;
  logic [3:0]        title_k;
  logic [5:0]        logo_k;
  logic [ADDR_BITS-1:0] logo_off;
  logic [ADDR_BITS-1:0] title_off;
  logic              in_hdr_sum;
  logic              in_gsum_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      title_low_q  <= '0;
      title_high_q <= '0;
      color_mode_q <= 1'b0;
      license_q    <= '0;
      cart_type_q  <= '0;
      rom_bank_q   <= '0;
      ram_size_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TITLE_LOW:  title_low_q  <= cfg_wdata_i;
        CFG_TITLE_HIGH: title_high_q <= cfg_wdata_i[55:0];
        CFG_COLOR_MODE: color_mode_q <= cfg_wdata_i[0];
        CFG_LICENSE:    license_q    <= cfg_wdata_i[7:0];
        CFG_CART_TYPE:  cart_type_q  <= cfg_wdata_i[7:0];
        CFG_ROM_BANK:   rom_bank_q   <= cfg_wdata_i[7:0];
        CFG_RAM_SIZE:   ram_size_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: a new byte is taken whenever the output register is free or being
  // emptied, unless a summary still has to go out first.
  assign out_fire = out_vld_q & out_m.ready;
  assign in_ready = ~pend_q & (~out_vld_q | out_m.ready);
  assign in_fire  = in_s.valid & in_ready;
  assign in_s.ready = in_ready;

  // Field offsets within the logo and title areas.
  assign logo_off  = addr_q - A_LOGO;
  assign title_off = addr_q - A_TITLE;
  assign logo_k    = logo_off[5:0];
  assign title_k   = title_off[3:0];
  assign title_all = {title_high_q, title_low_q};

  always_comb begin
    patched = in_s.rom_byte;
    if (addr_q >= A_LOGO && addr_q < A_TITLE) begin
      patched = LOGO_TABLE[logo_k];
    end else if (addr_q >= A_TITLE && addr_q < A_TEND) begin
      patched = to_upper(title_all[{title_k, 3'b000} +: 8]);
    end else begin
      case (addr_q)
        ADDR_BITS'(HDR_COLOR):   patched = color_mode_q ? COLOR_FLAG : 8'h00;
        ADDR_BITS'(HDR_LIC_HI):  patched = hex_digit(license_q[7:4]);
        ADDR_BITS'(HDR_LIC_LO):  patched = hex_digit(license_q[3:0]);
        ADDR_BITS'(HDR_OLD_SGB): patched = 8'h00;
        ADDR_BITS'(HDR_TYPE):    patched = cart_type_q;
        ADDR_BITS'(HDR_ROM):     patched = rom_bank_q;
        ADDR_BITS'(HDR_RAM):     patched = ram_size_q;
        ADDR_BITS'(HDR_DEST):    patched = DEST_BYTE;
        ADDR_BITS'(HDR_OLD_LIC): patched = OLD_LIC_BYTE;
        ADDR_BITS'(HDR_VERSION): patched = 8'h00;
        ADDR_BITS'(HDR_SUM_AT):  patched = hsum_q;
        default:                 patched = in_s.rom_byte;
      endcase
    end
  end

  assign in_hdr_sum   = (addr_q >= A_TITLE) && (addr_q <= A_VER);
  assign in_gsum_slot = (addr_q == A_GSUM0) || (addr_q == A_GSUM1);

  always_comb begin
    hsum_d = in_hdr_sum ? (hsum_q - patched - 8'd1) : hsum_q;
    gsum_d = in_gsum_slot ? gsum_q : (gsum_q + {8'h00, patched});
    addr_d = addr_q + ADDR_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      hsum_q <= '0;
      gsum_q <= '0;
    end else if (in_fire) begin
      if (in_s.final_byte) begin
        addr_q <= '0;
        hsum_q <= '0;
        gsum_q <= '0;
      end else begin
        addr_q <= addr_d;
        hsum_q <= hsum_d;
        gsum_q <= gsum_d;
      end
    end
  end

  // Control of the output register and the waiting summary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (in_fire) begin
      out_vld_q <= 1'b1;
      pend_q    <= in_s.final_byte;
    end else if (out_fire) begin
      out_vld_q <= pend_q;
      pend_q    <= 1'b0;
    end
  end

  // Payload of the output register; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= patched;
      out_summ_q <= 1'b0;
      out_hck_q  <= '0;
      out_gck_q  <= '0;
      out_end_q  <= ~in_s.final_byte;
      pend_hck_q <= hsum_d;
      pend_gck_q <= gsum_d;
    end else if (out_fire && pend_q) begin
      out_byte_q <= '0;
      out_summ_q <= 1'b1;
      out_hck_q  <= pend_hck_q;
      out_gck_q  <= pend_gck_q;
      out_end_q  <= 1'b1;
    end
  end

  assign out_m.valid           = out_vld_q;
  assign out_m.out_byte        = out_byte_q;
  assign out_m.is_summary      = out_summ_q;
  assign out_m.header_checksum = out_hck_q;
  assign out_m.global_checksum = out_gck_q;
  assign out_m.run_end         = out_end_q;

`ifndef SYNTHESIS
  a_pend_behind_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_vld_q && !out_summ_q && !out_end_q)
    else $error("summary waiting without a final byte in the output register");

  a_final_sets_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_s.final_byte |=> pend_q && addr_q == '0 && hsum_q == '0 && gsum_q == '0)
    else $error("final byte did not queue a summary and clear the image state");

  a_no_take_while_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_s.ready)
    else $error("byte accepted while a summary waits");

  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_summ_q |-> out_end_q && out_byte_q == '0)
    else $error("summary item malformed");

  a_pend_to_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && pend_q |=> out_vld_q && out_summ_q)
    else $error("summary lost after final byte left");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for rom_header_patch_checksum: streams ROM images through the patcher
// and compares each patched byte and checksum summary with a cycle-free model or a pinned row.
// Depends on rhpc_pkg and the rhpc_in_if / rhpc_out_if channel interfaces.
module tb;
  import rhpc_pkg::*;

  // A narrow address counter lets images run past the end of the address space and wrap.
  // This takes a few hundred bytes instead of millions, and the header map still fits below it.
  localparam int unsigned ADDR_W          = 9;
  localparam int unsigned ADDR_SPAN       = 1 << ADDR_W;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MIN_BYTES       = 1200;
  localparam int unsigned DIRECTED_IMAGES = 6;
  localparam int unsigned MIN_IMAGES      = 6;
  localparam int unsigned MAX_REPORTS     = 40;

  // This index lies past the last register, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // The fixed logo bytes, held here so that the bench does not rely on the block's copy.
  localparam logic [0:47][7:0] LOGO_BYTES = {
    8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0c, 8'h00, 8'h0d,
    8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
    8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99,
    8'hbb, 8'hbb, 8'h67, 8'h63, 8'h6e, 8'h0e, 8'hec, 8'hcc,
    8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e
  };

  typedef enum {REGS_ZERO, REGS_ONES, REGS_RANDOM} reg_style_e;
  typedef enum {SINK_FLOWING, SINK_COIN, SINK_MOSTLY, SINK_TOGGLE} sink_mode_e;

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              is_summary;
    logic [HSUM_W-1:0] header_checksum;
    logic [GSUM_W-1:0] global_checksum;
    logic              run_end;
  } patch_result_t;

  // One row of the directed table. A row may repeat its byte, XORed with the repeat index,
  // to walk up to the header; pinned rows carry their expected byte and sums typed in by hand.
  typedef struct {
    int unsigned       reps;
    logic [BYTE_W-1:0] rom_byte;
    logic              final_byte;
    logic              pinned;
    logic [BYTE_W-1:0] exp_byte;
    logic [HSUM_W-1:0] exp_hsum;
    logic [GSUM_W-1:0] exp_gsum;
  } stim_row_t;

  stim_row_t directed_rows [16] = '{
    // Images of one to three bytes stay below the logo, so every byte passes unchanged.
    '{1, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'h00, 16'h00FF},
    '{1, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 16'h0000},
    '{1, 8'h80, 1'b0, 1'b1, 8'h80, 8'h00, 16'h0000},
    '{1, 8'h7F, 1'b1, 1'b1, 8'h7F, 8'h00, 16'h00FF},
    '{1, 8'h55, 1'b0, 1'b1, 8'h55, 8'h00, 16'h0000},
    '{1, 8'hAA, 1'b0, 1'b1, 8'hAA, 8'h00, 16'h0000},
    '{1, 8'h01, 1'b1, 1'b1, 8'h01, 8'h00, 16'h0100},
    // A full header: filler, logo, title, header fields, the header checksum slot,
    // the two global checksum slots and two body bytes.
    '{LOGO_START, 8'h61, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{LOGO_LEN,   8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{TITLE_LEN,  8'h61, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{10,         8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{1,          8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{2,          8'hC3, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{2,          8'h10, 1'b1, 1'b0, 8'h00, 8'h00, 16'h0000},
    // A short image that stops in the middle of the title.
    '{32'h13A,    8'h3C, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
    '{1,          8'h99, 1'b1, 1'b0, 8'h00, 8'h00, 16'h0000}
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rhpc_in_if  in_ch ();
  rhpc_out_if out_ch ();

  rom_header_patch_checksum #(.ADDR_BITS(ADDR_W)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_s        (in_ch),
    .out_m       (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model copy of the configuration registers, as they stand after reset.
  logic [63:0]       title_lo = '0;
  logic [55:0]       title_hi = '0;
  logic              color_on = 1'b0;
  logic [BYTE_W-1:0] license  = '0;
  logic [BYTE_W-1:0] cart     = '0;
  logic [BYTE_W-1:0] rom_code = '0;
  logic [BYTE_W-1:0] ram_code = '0;

  // Model copy of the running state of the image being streamed.
  logic [ADDR_W-1:0] img_addr = '0;
  logic [HSUM_W-1:0] hdr_sum  = '0;
  logic [GSUM_W-1:0] img_sum  = '0;

  patch_result_t pending_results [$];

  int unsigned bytes_fed    = 0;
  int unsigned images_fed   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;
  bit          hold_off_req = 1'b0;

  // The ASCII character of a hex digit, in upper case.
  function automatic logic [BYTE_W-1:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
  endfunction

  // Mirrors a register write; an index past the list and bits above a register's width
  // are dropped, as the block is required to do.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TITLE_LOW:  title_lo = data;
      CFG_TITLE_HIGH: title_hi = data[55:0];
      CFG_COLOR_MODE: color_on = data[0];
      CFG_LICENSE:    license  = data[7:0];
      CFG_CART_TYPE:  cart     = data[7:0];
      CFG_ROM_BANK:   rom_code = data[7:0];
      CFG_RAM_SIZE:   ram_code = data[7:0];
      default: ;
    endcase
  endfunction

  // Patches one image byte by its address, moves both sums and the address on, and returns
  // the byte result and, for the last byte of an image, the summary that follows it.
  function automatic void patch_and_sum(input logic [BYTE_W-1:0] b, input logic fin,
                                        output patch_result_t byte_res,
                                        output patch_result_t sum_res);
    int unsigned       ai;
    int unsigned       k;
    logic [BYTE_W-1:0] p;
    ai = 32'(img_addr);
    p  = b;
    if (ai >= LOGO_START && ai < TITLE_START) begin
      p = LOGO_BYTES[ai - LOGO_START];
    end else if (ai >= TITLE_START && ai < TITLE_START + TITLE_LEN) begin
      k = ai - TITLE_START;
      p = (k < 8) ? title_lo[8*k +: 8] : title_hi[8*(k-8) +: 8];
      // Only the letters a to z are raised to upper case.
      if (p >= 8'h61 && p <= 8'h7A) begin
        p = p - 8'h20;
      end
    end else begin
      case (ai)
        HDR_COLOR:   p = color_on ? COLOR_FLAG : 8'h00;
        HDR_LIC_HI:  p = ascii_hex(license[7:4]);
        HDR_LIC_LO:  p = ascii_hex(license[3:0]);
        HDR_OLD_SGB: p = 8'h00;
        HDR_TYPE:    p = cart;
        HDR_ROM:     p = rom_code;
        HDR_RAM:     p = ram_code;
        HDR_DEST:    p = DEST_BYTE;
        HDR_OLD_LIC: p = OLD_LIC_BYTE;
        HDR_VERSION: p = 8'h00;
        HDR_SUM_AT:  p = hdr_sum;
        default: ;
      endcase
    end
    if (ai >= TITLE_START && ai <= HDR_VERSION) begin
      hdr_sum = hdr_sum - p - 8'd1;
    end
    if (ai != GSUM_AT && ai != GSUM_AT + 1) begin
      img_sum = img_sum + {8'h00, p};
    end
    img_addr = img_addr + ADDR_W'(1);
    byte_res = '{out_byte: p, is_summary: 1'b0, header_checksum: '0, global_checksum: '0,
                 run_end: !fin};
    sum_res  = '{out_byte: '0, is_summary: 1'b1, header_checksum: hdr_sum,
                 global_checksum: img_sum, run_end: 1'b1};
    if (fin) begin
      img_addr = '0;
      hdr_sum  = '0;
      img_sum  = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch in %s of result %0d: got 0x%0h, expected 0x%0h",
               what, results_seen, got, want);
    end
  endtask

  // Offers one item and waits until it is taken. The sender works in bursts, now and then
  // a long one; between bursts valid usually drops, but sometimes it stays high.
  task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic fin, input logic pinned,
                           input logic [BYTE_W-1:0] exp_byte, input logic [HSUM_W-1:0] exp_hsum,
                           input logic [GSUM_W-1:0] exp_gsum);
    int unsigned   gap;
    patch_result_t byte_res;
    patch_result_t sum_res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.rom_byte   <= b;
    in_ch.final_byte <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    bytes_fed++;
    patch_and_sum(b, fin, byte_res, sum_res);
    if (pinned) begin
      byte_res.out_byte       = exp_byte;
      sum_res.header_checksum = exp_hsum;
      sum_res.global_checksum = exp_gsum;
    end
    pending_results.push_back(byte_res);
    if (fin) begin
      pending_results.push_back(sum_res);
      images_fed++;
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes every register in turn, then the unused index. The block must be idle.
  task automatic program_regs(input reg_style_e style);
    logic [63:0] v;
    int unsigned pick;
    for (int i = 0; i <= int'(CFG_RAM_SIZE); i++) begin
      case (style)
        REGS_ZERO: v = '0;
        REGS_ONES: v = '1;
        default: begin
          v    = {$urandom, $urandom};
          pick = $urandom_range(0, 5);
          if (pick == 0) begin
            v = '0;
          end else if (pick == 1) begin
            v = '1;
          end else if (i <= int'(CFG_TITLE_HIGH)) begin
            // Title characters lean towards the letters and their neighbours, so that
            // the edges of the upper-case range are hit often.
            for (int j = 0; j < 8; j++) begin
              if ($urandom_range(0, 2) != 0) begin
                v[8*j +: 8] = 8'h60 + 8'($urandom_range(0, 27));
              end
            end
          end
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_e'(i);
      cfg_wdata <= v;
      @(posedge clk_i);
      apply_reg(cfg_idx_e'(i), v);
    end
    cfg_idx   <= CFG_SPARE;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk_i);
    apply_reg(CFG_SPARE, cfg_wdata);
    cfg_we <= 1'b0;
  endtask

  // Result checker: every accepted result is held against the oldest expectation.
  always @(posedge clk_i) begin
    patch_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 16'(out_ch.out_byte), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          report_mismatch("out_byte", 16'(out_ch.out_byte), 16'(want.out_byte));
        end
        if (out_ch.is_summary !== want.is_summary) begin
          report_mismatch("is_summary", 16'(out_ch.is_summary), 16'(want.is_summary));
        end
        if (out_ch.header_checksum !== want.header_checksum) begin
          report_mismatch("header_checksum", 16'(out_ch.header_checksum),
                          16'(want.header_checksum));
        end
        if (out_ch.global_checksum !== want.global_checksum) begin
          report_mismatch("global_checksum", out_ch.global_checksum, want.global_checksum);
        end
        if (out_ch.run_end !== want.run_end) begin
          report_mismatch("run_end", 16'(out_ch.run_end), 16'(want.run_end));
        end
      end
    end
  end

  // Receiver: ready follows a pattern of its own, picked anew for each random span.
  // On request it holds off for a long stretch, so that the block fills and stalls its input.
  initial begin
    int unsigned span;
    sink_mode_e  mode;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        mode = sink_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 120);
        for (int k = 0; k < span && !hold_off_req; k++) begin
          case (mode)
            SINK_FLOWING: out_ch.ready <= 1'b1;
            SINK_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
            SINK_MOSTLY:  out_ch.ready <= ($urandom_range(0, 7) != 0);
            default:      out_ch.ready <= ~out_ch.ready;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus: reset, the directed table with the registers as reset leaves them, then
  // random images until enough bytes and summaries have gone through. The first random
  // image runs with every register at all ones, starts under a long hold-off and runs
  // past the end of the address space.
  initial begin
    int unsigned len;
    int unsigned sel;
    logic        last;
    in_ch.valid      = 1'b0;
    in_ch.rom_byte   = '0;
    in_ch.final_byte = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        last = directed_rows[r].final_byte && (k == directed_rows[r].reps - 1);
        feed_byte(directed_rows[r].rom_byte ^ k[7:0], last, directed_rows[r].pinned,
                  directed_rows[r].exp_byte, directed_rows[r].exp_hsum,
                  directed_rows[r].exp_gsum);
      end
    end

    // Random images. Most are tiny; some cover the whole header, some stop inside it,
    // and a few run past the end of the address space so that bytes are patched again
    // by their wrapped address.
    while (bytes_fed < MIN_BYTES || images_fed < DIRECTED_IMAGES + MIN_IMAGES) begin
      if (images_fed == DIRECTED_IMAGES) begin
        drain_results();
        program_regs(REGS_ONES);
        hold_off_req = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        drain_results();
        program_regs(REGS_RANDOM);
      end
      if ($urandom_range(0, 9) == 0) begin
        hold_off_req = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (images_fed == DIRECTED_IMAGES) begin
        len = $urandom_range(ADDR_SPAN + 1, ADDR_SPAN + 24);
      end else if (sel < 80) begin
        len = $urandom_range(1, 24);
      end else if (sel < 90) begin
        len = $urandom_range(HDR_SUM_AT + 1, 32'h170);
      end else if (sel < 96) begin
        len = $urandom_range(LOGO_START, GSUM_AT + 1);
      end else begin
        len = $urandom_range(ADDR_SPAN, ADDR_SPAN + 32'h170);
      end
      for (int k = 0; k < len; k++) begin
        // Once in a while the sender pauses mid-image until everything has come back.
        if ($urandom_range(0, 399) == 0) begin
          drain_results();
        end
        feed_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, '0, '0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/rhpc_pkg.sv
rtl/core/rhpc_if.sv
rtl/core/rom_header_patch_checksum.sv
bench/tb.sv
